@@ sv/smc_pkg.sv @@
// Shared constants, widths and a helper for the sidewinder maze carver.
package smc_pkg;

    localparam int MAX_SIDE_DEF = 64;   // default largest maze side
    localparam int SIDE_CAP     = 64;   // hard cap on a side from the 6-bit coordinates
    localparam int PICK_W       = 16;   // width of the random pick word
    localparam int COORD_W      = 6;    // width of row and column result fields
    localparam int CFG_W        = 7;    // width of a size register
    localparam int CFG_IDX_W    = 1;    // width of the register index

    localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] MAZE_WIDTH_RST  = 7'd16;
    localparam logic [CFG_W-1:0] MAZE_HEIGHT_RST = 7'd16;

    // A size of zero behaves as one; a size above the limit behaves as the limit.
    function automatic logic [CFG_W-1:0] eff_side(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ sv/smc_mod.sv @@
// Iterative restoring modulo unit: one quotient bit of the pick word per cycle.
module smc_mod #(
    parameter int CW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [smc_pkg::PICK_W-1:0] i_dividend,
    input  logic [CW:0]               i_divisor,
    output logic                      o_done,
    output logic [CW-1:0]             o_rem
);

    localparam int STEP_W = $clog2(smc_pkg::PICK_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [smc_pkg::PICK_W-1:0] r_dvd;
    logic [CW:0]                r_div;
    logic [CW-1:0]              r_rem;
    logic [CW:0]                n_trial;
    logic [CW-1:0]              n_rem;

    // Shift the next dividend bit into the partial remainder and subtract when it fits.
    always_comb begin
        n_trial = {r_rem, r_dvd[smc_pkg::PICK_W-1]};
        if (n_trial >= r_div) begin
            n_rem = CW'(n_trial - r_div);
        end else begin
            n_rem = CW'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(smc_pkg::PICK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[smc_pkg::PICK_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ sv/sidewinder_maze_carver_top.sv @@
// Top level of the sidewinder maze carver: walk sequencer, size registers and result register.
// A cell that opens east, or any top-row cell, passes from the idle state to the emit state and
// then to the result register. A cell that closes a run and opens north waits in the divide state
// while the modulo unit runs its 16 one-bit steps, then goes to the emit state. One cell is in
// flight at a time, so the next cell waits until the sequencer is idle; carve stalls delay that.
// Reset (synchronous, active low) returns the walk to row 0, column 0 with run start 0,
// sets both sizes to 16 and empties the result register.
module sidewinder_maze_carver_top #(
    parameter int MAX_SIDE = smc_pkg::MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Cell input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_coin,
    input  logic [smc_pkg::PICK_W-1:0]    i_pick,
    // Carve command channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [smc_pkg::COORD_W-1:0]   o_row,
    output logic [smc_pkg::COORD_W-1:0]   o_column,
    output logic                          o_carve_east,
    output logic                          o_carve_north,
    output logic [smc_pkg::COORD_W-1:0]   o_north_column,
    output logic                          o_maze_done,
    // Size register write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [smc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [smc_pkg::CFG_W-1:0]     i_cfg_data
);

    // The usable side is the smaller of the parameter and the coordinate cap.
    localparam int LIM = (MAX_SIDE < smc_pkg::SIDE_CAP) ? MAX_SIDE : smc_pkg::SIDE_CAP;
    localparam int CW  = $clog2(LIM);   // bits of a column, row or run start
    localparam int EW  = CW + 1;        // bits of a side length or run length

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state                      r_state;
    logic [smc_pkg::CFG_W-1:0]   r_width;
    logic [smc_pkg::CFG_W-1:0]   r_height;
    logic [CW-1:0]               r_col;
    logic [CW-1:0]               r_row;
    logic [CW-1:0]               r_rs;

    // The cell being worked on.
    logic [CW-1:0]               r_cell_col;
    logic [CW-1:0]               r_cell_row;
    logic [CW-1:0]               r_cell_rs;
    logic                        r_cell_east;
    logic                        r_cell_north;
    logic                        r_cell_done;

    // Result register.
    logic                        r_out_valid;
    logic [CW-1:0]               r_out_row;
    logic [CW-1:0]               r_out_col;
    logic                        r_out_east;
    logic                        r_out_north;
    logic [CW-1:0]               r_out_ncol;
    logic                        r_out_done;

    logic [EW-1:0]               w_side;
    logic [EW-1:0]               h_side;
    logic                        wrap;
    logic [CW-1:0]               cur_x;
    logic [CW-1:0]               cur_y;
    logic [CW-1:0]               rs_raw;
    logic [CW-1:0]               cur_rs;
    logic                        last_in_row;
    logic                        close_run;
    logic                        maze_end;
    logic [EW-1:0]               run_len;
    logic [CW-1:0]               n_col;
    logic [CW-1:0]               n_row;
    logic [CW-1:0]               n_rs;
    logic                        in_beat;
    logic                        out_free;
    logic                        div_done;
    logic [CW-1:0]               div_rem;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Effective maze size after clamping the registers into range.
    assign w_side = EW'(smc_pkg::eff_side(r_width,  smc_pkg::CFG_W'(LIM)));
    assign h_side = EW'(smc_pkg::eff_side(r_height, smc_pkg::CFG_W'(LIM)));

    // Walk decision for the arriving cell. A size change that leaves the counters
    // outside the maze restarts the walk at the first cell.
    always_comb begin
        wrap        = ({1'b0, r_col} >= w_side) || ({1'b0, r_row} >= h_side);
        cur_x       = wrap ? '0 : r_col;
        cur_y       = wrap ? '0 : r_row;
        rs_raw      = wrap ? '0 : r_rs;
        cur_rs      = (rs_raw > cur_x) ? cur_x : rs_raw;
        last_in_row = ({1'b0, cur_x} + EW'(1)) == w_side;
        close_run   = (cur_y != '0) && (last_in_row || !i_coin);
        maze_end    = last_in_row && (({1'b0, cur_y} + EW'(1)) == h_side);
        run_len     = {1'b0, cur_x} - {1'b0, cur_rs} + EW'(1);
        if (last_in_row) begin
            n_col = '0;
            n_rs  = '0;
            n_row = maze_end ? '0 : cur_y + CW'(1);
        end else begin
            n_col = cur_x + CW'(1);
            n_row = cur_y;
            n_rs  = close_run ? cur_x + CW'(1) : cur_rs;
        end
    end

    // The north column is the run start plus the pick reduced by the run length.
    smc_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_beat && close_run),
        .i_dividend (i_pick),
        .i_divisor  (run_len),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Size registers accept a write every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= smc_pkg::MAZE_WIDTH_RST;
            r_height <= smc_pkg::MAZE_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                smc_pkg::CFG_MAZE_WIDTH:  r_width  <= i_cfg_data;
                smc_pkg::CFG_MAZE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: take a cell, run the modulo unit when a run closes, then hand the
    // carve command to the result register once it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_rs        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the emit state the result register is refilled below instead.
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_col        <= n_col;
                        r_row        <= n_row;
                        r_rs         <= n_rs;
                        r_cell_col   <= cur_x;
                        r_cell_row   <= cur_y;
                        r_cell_rs    <= cur_rs;
                        r_cell_east  <= !close_run && !last_in_row;
                        r_cell_north <= close_run;
                        r_cell_done  <= maze_end;
                        r_state      <= close_run ? ST_DIV : ST_EMIT;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_cell_row;
                        r_out_col   <= r_cell_col;
                        r_out_east  <= r_cell_east;
                        r_out_north <= r_cell_north;
                        r_out_ncol  <= r_cell_north ? r_cell_rs + div_rem : '0;
                        r_out_done  <= r_cell_done;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A new cell is taken only while the sequencer is idle.
    assign o_in_stall = (r_state != ST_IDLE);

    assign o_out_valid    = r_out_valid;
    assign o_row          = smc_pkg::COORD_W'(r_out_row);
    assign o_column       = smc_pkg::COORD_W'(r_out_col);
    assign o_carve_east   = r_out_east;
    assign o_carve_north  = r_out_north;
    assign o_north_column = smc_pkg::COORD_W'(r_out_ncol);
    assign o_maze_done    = r_out_done;

endmodule
